[src/cwc_pkg.sv]
// Shared types, constants, microcode program and helpers of the credit window controller.
package cwc_pkg;

   localparam int MAX_WINDOW_DEF = 64;

   localparam int CMD_W       = 2;
   localparam int CORES_W     = 9;
   localparam int DELAY_W     = 16;
   localparam int SESS_W      = 16;
   localparam int DRAIN_W     = 16;
   localparam int OLD_W       = 6;
   localparam int PEND_W      = 7;
   localparam int DEMAND_W    = 16;
   localparam int OUT_WIN_W   = 22;
   localparam int WAKE_W      = 16;
   localparam int STATE_W     = 23;
   localparam int W_W         = 26;
   localparam int Q_W         = 24;
   localparam int PDM_W       = 25;
   localparam int FAC_W       = 9;

   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 72;
   localparam int RSP_USED_W  = OLD_W + 2 * OUT_WIN_W + WAKE_W;

   localparam logic [CORES_W-1:0] CORES_RST = 9'd8;
   localparam logic [STATE_W-1:0] STATE_MAX = {STATE_W{1'b1}};

   localparam int DIV_W          = 32;
   localparam int DSR_W          = 16;
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_STEPS      = DIV_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   localparam logic [DELAY_W-1:0] DELAY_MIN = 16'd80;
   localparam logic [DELAY_W-1:0] DELAY_SAT = 16'd280;
   localparam logic [DELAY_W-1:0] F_BASE    = 16'd480;
   localparam logic [FAC_W-1:0]   F_MIN     = 9'd200;
   localparam logic [DSR_W-1:0]   F_DEN     = 16'd400;
   localparam logic [DSR_W-1:0]   GROW_DEN  = 16'd500;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK,
      CMD_UPDATE,
      CMD_TRIM,
      CMD_RELEASE
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_TICK_DIV,
      OP_TICK_GROW,
      OP_TICK_CLAMP,
      OP_TICK_WAKE,
      OP_TICK_COMMIT,
      OP_UPD_DIV,
      OP_UPD_MARGIN,
      OP_UPD_BASE,
      OP_UPD_RAISE,
      OP_UPD_LIMIT,
      OP_UPD_COMMIT,
      OP_TRIM_COMMIT,
      OP_RELEASE_COMMIT,
      OP_KEEP_COMMIT
   } uop_type;

   typedef enum logic [2:0] {
      JMP_IDLE,
      JMP_DISPATCH,
      JMP_NEXT,
      JMP_WAIT,
      JMP_DRAINED,
      JMP_EMIT
   } jmp_type;

   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type S_IDLE      = 5'd0;
   localparam step_type S_TICK_DIV  = 5'd1;
   localparam step_type S_TICK_WAIT = 5'd2;
   localparam step_type S_TICK_GROW = 5'd3;
   localparam step_type S_TICK_CLMP = 5'd4;
   localparam step_type S_TICK_WAKE = 5'd5;
   localparam step_type S_TICK_CMT  = 5'd6;
   localparam step_type S_UPD_DIV   = 5'd7;
   localparam step_type S_UPD_WAIT  = 5'd8;
   localparam step_type S_UPD_MARG  = 5'd9;
   localparam step_type S_UPD_BASE  = 5'd10;
   localparam step_type S_UPD_RAISE = 5'd11;
   localparam step_type S_UPD_LIMIT = 5'd12;
   localparam step_type S_UPD_CMT   = 5'd13;
   localparam step_type S_TRIM_CMT  = 5'd14;
   localparam step_type S_REL_CMT   = 5'd15;
   localparam step_type S_KEEP_CMT  = 5'd16;

   typedef struct packed {
      uop_type  op;
      jmp_type  jmp;
      step_type target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type u;
      u = '{op: OP_NOP, jmp: JMP_IDLE, target: S_IDLE};
      case (s)
         S_IDLE:      u = '{op: OP_NOP,            jmp: JMP_DISPATCH, target: S_IDLE};
         S_TICK_DIV:  u = '{op: OP_TICK_DIV,       jmp: JMP_NEXT,     target: S_IDLE};
         S_TICK_WAIT: u = '{op: OP_NOP,            jmp: JMP_WAIT,     target: S_IDLE};
         S_TICK_GROW: u = '{op: OP_TICK_GROW,      jmp: JMP_NEXT,     target: S_IDLE};
         S_TICK_CLMP: u = '{op: OP_TICK_CLAMP,     jmp: JMP_NEXT,     target: S_IDLE};
         S_TICK_WAKE: u = '{op: OP_TICK_WAKE,      jmp: JMP_NEXT,     target: S_IDLE};
         S_TICK_CMT:  u = '{op: OP_TICK_COMMIT,    jmp: JMP_EMIT,     target: S_IDLE};
         S_UPD_DIV:   u = '{op: OP_UPD_DIV,        jmp: JMP_DRAINED,  target: S_KEEP_CMT};
         S_UPD_WAIT:  u = '{op: OP_NOP,            jmp: JMP_WAIT,     target: S_IDLE};
         S_UPD_MARG:  u = '{op: OP_UPD_MARGIN,     jmp: JMP_NEXT,     target: S_IDLE};
         S_UPD_BASE:  u = '{op: OP_UPD_BASE,       jmp: JMP_NEXT,     target: S_IDLE};
         S_UPD_RAISE: u = '{op: OP_UPD_RAISE,      jmp: JMP_NEXT,     target: S_IDLE};
         S_UPD_LIMIT: u = '{op: OP_UPD_LIMIT,      jmp: JMP_NEXT,     target: S_IDLE};
         S_UPD_CMT:   u = '{op: OP_UPD_COMMIT,     jmp: JMP_EMIT,     target: S_IDLE};
         S_TRIM_CMT:  u = '{op: OP_TRIM_COMMIT,    jmp: JMP_EMIT,     target: S_IDLE};
         S_REL_CMT:   u = '{op: OP_RELEASE_COMMIT, jmp: JMP_EMIT,     target: S_IDLE};
         S_KEEP_CMT:  u = '{op: OP_KEEP_COMMIT,    jmp: JMP_EMIT,     target: S_IDLE};
         default:     u = '{op: OP_NOP,            jmp: JMP_IDLE,     target: S_IDLE};
      endcase
      return u;
   endfunction

   function automatic step_type entry_step(input cmd_type c);
      step_type s;
      case (c)
         CMD_TICK:    s = S_TICK_DIV;
         CMD_UPDATE:  s = S_UPD_DIV;
         CMD_TRIM:    s = S_TRIM_CMT;
         CMD_RELEASE: s = S_REL_CMT;
         default:     s = S_IDLE;
      endcase
      return s;
   endfunction

   function automatic logic [STATE_W-1:0] sat_state(input logic signed [W_W-1:0] v);
      logic [STATE_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(W_W'(STATE_MAX))) begin
         r = STATE_MAX;
      end else begin
         r = v[STATE_W-1:0];
      end
      return r;
   endfunction

endpackage

[src/cwc_div.sv]
// Iterative unsigned divider, four quotient bits per cycle.
module cwc_div
   import cwc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      div_req,
   output logic             div_busy,
   output logic [DIV_W-1:0] div_quot
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [DSR_W:0]       rem_ff, rem_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;

   always_comb begin
      logic [DSR_W:0]   r;
      logic [DIV_W-1:0] q;
      r = rem_ff;
      q = quot_ff;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         r = {r[DSR_W-1:0], q[DIV_W-1]};
         q = {q[DIV_W-2:0], 1'b0};
         if (r >= {1'b0, dsr_ff}) begin
            r    = r - {1'b0, dsr_ff};
            q[0] = 1'b1;
         end
      end
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         quot_in = q;
         rem_in  = r;
         cnt_in  = cnt_ff + 1'b1;
         busy_in = (cnt_ff != DIV_CNT_W'(DIV_STEPS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign div_busy = busy_ff;
   assign div_quot = quot_ff;

endmodule

[src/rpc_credit_window_controller.sv]
// Top level of the RPC server credit window controller: microcoded sequencer and datapath.
//
// Keeps the server's global credit window and the credits held by sessions. Each request
// (tick, session window update, trim, release) yields exactly one response. A small
// microprogram steps a shared datapath; an iterative divider (4 bits per cycle) does the
// window scaling by 400, the growth by sessions/500 and the per-session margin. A tick
// starts the divider, waits for it, then grows, clamps, computes wakes and commits; a session
// update starts the divider, waits, then sets margin, base, raise and limit before its commit.
// Trim and release respond from a single commit step, and an update of a drained session
// skips the divider and goes straight to its commit step. After each commit the sequencer
// returns to its idle step, where the next request is taken. The response sits in an output
// register, so the next request is taken while it waits; a response still waiting there
// holds the next one at its commit step. Configuration (the core count) is written through
// the csr channel; the user must do so only while no request is in flight, and the block itself does not enforce this.
module rpc_credit_window_controller
   import cwc_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // queue_delay_us, session_count, drained_count, old_window, pending_requests,
   // client_demand, wake_flag, sync_flag, dropped_flag, in_drained_list
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic [CMD_W-1:0]       req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // session_window, global_window, credits_in_use, wake_count
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CORES_W-1:0]     csr_data
);

   step_type  step_ff, step_in;
   ucode_type uc;
   logic      fire, emit, out_free;

   logic [CORES_W-1:0]     core_cnt_ff;
   logic [STATE_W-1:0]     gw_ff, gw_in, cu_ff, cu_in;

   logic [DELAY_W-1:0]  delay_ff;
   logic [SESS_W-1:0]   sess_ff;
   logic [DRAIN_W-1:0]  drain_ff;
   logic [OLD_W-1:0]    old_ff;
   logic [PEND_W-1:0]   pend_ff;
   logic [DEMAND_W-1:0] demand_ff;
   logic                wake_flag_ff, sync_ff, dropped_ff, drained_ff;

   logic signed [W_W-1:0] w_ff, w_in, open_ff, open_in;
   logic [Q_W-1:0]        margin_ff, margin_in;
   logic [PDM_W-1:0]      pdm_ff, pdm_in;
   logic [WAKE_W-1:0]     wake_ff, wake_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OLD_W-1:0]     rsp_sw_ff, rsp_sw_in;
   logic [OUT_WIN_W-1:0] rsp_gw_ff, rsp_cu_ff;
   logic [WAKE_W-1:0]    rsp_wake_ff, rsp_wake_in;

   div_req_type      div_req;
   logic             div_busy;
   logic [DIV_W-1:0] div_quot;

   cwc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_busy (div_busy),
      .div_quot (div_quot)
   );

   assign uc         = ucode_rom(step_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = (uc.jmp != JMP_EMIT) || out_free;
   assign req_tready = (uc.jmp == JMP_DISPATCH);
   assign csr_ready  = 1'b1;

   always_comb begin
      step_in = step_ff;
      case (uc.jmp)
         JMP_DISPATCH: if (req_tvalid) step_in = entry_step(cmd_type'(req_tuser));
         JMP_NEXT:     step_in = step_ff + 1'b1;
         JMP_WAIT:     if (!div_busy) step_in = step_ff + 1'b1;
         JMP_DRAINED:  step_in = drained_ff ? uc.target : step_ff + 1'b1;
         JMP_EMIT:     if (out_free) step_in = S_IDLE;
         default:      step_in = S_IDLE;
      endcase
   end

   always_comb begin
      logic signed [W_W-1:0] t, ow, mc_s, lim_s, open_s, pd_s, pdm_s, m_s, p_s, cap_s;
      logic [FAC_W-1:0]      f;
      logic [Q_W-1:0]        m;
      ow     = $signed(W_W'(old_ff));
      pdm_s  = $signed(W_W'(pdm_ff));
      m_s    = $signed(W_W'(margin_ff));
      t      = w_ff;
      f      = F_MIN;
      m      = '0;
      mc_s   = '0;
      lim_s  = '0;
      open_s = '0;
      pd_s   = '0;
      p_s    = '0;
      cap_s  = '0;
      w_in      = w_ff;
      open_in   = open_ff;
      margin_in = margin_ff;
      pdm_in    = pdm_ff;
      wake_in   = wake_ff;
      gw_in     = gw_ff;
      cu_in     = cu_ff;
      div_req   = '0;
      emit      = 1'b0;
      rsp_sw_in   = old_ff;
      rsp_wake_in = '0;
      if (fire) begin
         case (uc.op)
            OP_TICK_DIV: begin
               div_req.start = 1'b1;
               if (delay_ff >= DELAY_MIN) begin
                  f = (delay_ff >= DELAY_SAT) ? F_MIN : FAC_W'(F_BASE - delay_ff);
                  div_req.dividend = DIV_W'(gw_ff) * DIV_W'(f);
                  div_req.divisor  = F_DEN;
               end else begin
                  div_req.dividend = DIV_W'(sess_ff);
                  div_req.divisor  = GROW_DEN;
               end
            end
            OP_TICK_GROW: begin
               if (delay_ff >= DELAY_MIN) begin
                  w_in = $signed(W_W'(div_quot[Q_W-1:0]));
               end else if (div_quot == '0) begin
                  w_in = $signed(W_W'(gw_ff)) + $signed(W_W'(1));
               end else begin
                  w_in = $signed(W_W'(gw_ff)) + $signed(W_W'(div_quot[Q_W-1:0]));
               end
            end
            OP_TICK_CLAMP: begin
               mc_s  = $signed(W_W'(core_cnt_ff));
               lim_s = $signed(W_W'(sess_ff)) * $signed(W_W'(MAX_WINDOW));
               t     = (w_ff < mc_s) ? mc_s : w_ff;
               w_in  = (t > lim_s) ? lim_s : t;
            end
            OP_TICK_WAKE: begin
               open_s = w_ff - $signed(W_W'(cu_ff));
               if (open_s > 0) begin
                  wake_in = (open_s < $signed(W_W'(drain_ff))) ? open_s[WAKE_W-1:0] : drain_ff;
               end else begin
                  wake_in = '0;
               end
            end
            OP_TICK_COMMIT: begin
               emit        = 1'b1;
               gw_in       = sat_state(w_ff);
               cu_in       = sat_state($signed(W_W'(cu_ff)) + $signed(W_W'(wake_ff)));
               rsp_wake_in = wake_ff;
            end
            OP_UPD_DIV: begin
               open_s  = $signed(W_W'(gw_ff)) - $signed(W_W'(cu_ff));
               open_in = open_s;
               div_req.start    = !drained_ff;
               div_req.dividend = (open_s > 0) ? DIV_W'(open_s[STATE_W-1:0]) : '0;
               div_req.divisor  = (sess_ff == '0) ? DSR_W'(1) : sess_ff;
            end
            OP_UPD_MARGIN: begin
               if (open_ff > 0 && div_quot != '0) begin
                  m = div_quot[Q_W-1:0];
               end else begin
                  m = Q_W'(1);
               end
               margin_in = m;
               pdm_in    = PDM_W'(pend_ff) + PDM_W'(demand_ff) + PDM_W'(m);
            end
            OP_UPD_BASE: begin
               if (open_ff > 0) begin
                  t    = ow + open_ff;
                  w_in = (pdm_s < t) ? pdm_s : t;
               end else if (open_ff < 0) begin
                  w_in = ow - $signed(W_W'(1));
               end else begin
                  w_in = ow;
               end
            end
            OP_UPD_RAISE: begin
               if (wake_flag_ff || sess_ff <= SESS_W'(core_cnt_ff)) begin
                  if (t < m_s) t = m_s;
               end
               if (old_ff != '0 && t == 0 && !dropped_ff && !sync_ff) t = m_s;
               w_in = t;
            end
            OP_UPD_LIMIT: begin
               p_s   = $signed(W_W'(pend_ff));
               cap_s = $signed(W_W'(MAX_WINDOW - 1));
               if (t < p_s) t = p_s;
               if (t > cap_s) t = cap_s;
               if (t > pdm_s) t = pdm_s;
               w_in = t;
            end
            OP_UPD_COMMIT: begin
               emit      = 1'b1;
               cu_in     = sat_state($signed(W_W'(cu_ff)) + w_ff - ow);
               rsp_sw_in = w_ff[OLD_W-1:0];
            end
            OP_TRIM_COMMIT: begin
               emit = 1'b1;
               pd_s = $signed(W_W'(pend_ff)) + $signed(W_W'(demand_ff));
               if (ow > pd_s) begin
                  rsp_sw_in = pd_s[OLD_W-1:0];
                  cu_in     = sat_state($signed(W_W'(cu_ff)) - (ow - pd_s));
               end
            end
            OP_RELEASE_COMMIT: begin
               emit      = 1'b1;
               cu_in     = sat_state($signed(W_W'(cu_ff)) - ow);
               rsp_sw_in = '0;
            end
            OP_KEEP_COMMIT: begin
               emit = 1'b1;
            end
            default: begin
            end
         endcase
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= S_IDLE;
         core_cnt_ff  <= CORES_RST;
         gw_ff        <= STATE_W'(CORES_RST);
         cu_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         gw_ff        <= gw_in;
         cu_ff        <= cu_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) core_cnt_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      open_ff   <= open_in;
      margin_ff <= margin_in;
      pdm_ff    <= pdm_in;
      wake_ff   <= wake_in;
      if (req_tvalid && req_tready) begin
         delay_ff     <= req_tdata[15:0];
         sess_ff      <= req_tdata[31:16];
         drain_ff     <= req_tdata[47:32];
         old_ff       <= req_tdata[53:48];
         pend_ff      <= req_tdata[60:54];
         demand_ff    <= req_tdata[76:61];
         wake_flag_ff <= req_tdata[77];
         sync_ff      <= req_tdata[78];
         dropped_ff   <= req_tdata[79];
         drained_ff   <= req_tdata[80];
      end
      if (emit) begin
         rsp_sw_ff   <= rsp_sw_in;
         rsp_gw_ff   <= gw_in[OUT_WIN_W-1:0];
         rsp_cu_ff   <= cu_in[OUT_WIN_W-1:0];
         rsp_wake_ff <= rsp_wake_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                        rsp_wake_ff, rsp_cu_ff, rsp_gw_ff, rsp_sw_ff};

`ifndef SYNTHESIS
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      step_ff == S_IDLE |-> !div_busy)
      else $error("divider busy while sequencer idle");

   a_gw_tick_only: assert property (@(posedge clock) disable iff (reset)
      emit && uc.op != OP_TICK_COMMIT |=> $stable(gw_ff))
      else $error("global window changed outside tick");

   a_upd_range: assert property (@(posedge clock) disable iff (reset)
      step_ff == S_UPD_CMT |-> w_ff >= 0 && w_ff <= $signed(W_W'(MAX_WINDOW - 1)))
      else $error("session window out of range at commit");

   a_wake_tick_only: assert property (@(posedge clock) disable iff (reset)
      emit && uc.op != OP_TICK_COMMIT |=> rsp_wake_ff == '0)
      else $error("wake count on non-tick response");
`endif

endmodule

[tb/tb_rpc_credit_window_controller.sv]
// Self-checking testbench for the credit window controller: directed table, random traffic, checker.
module tb_rpc_credit_window_controller;
   import cwc_pkg::*;

   localparam longint STATE_CEIL = 64'd8388607;
   localparam longint SESS_CAP   = longint'(MAX_WINDOW_DEF);
   localparam longint KNEE_US    = 80;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] delay;
      logic [15:0] sessions;
      logic [15:0] drained;
      logic [5:0]  old_win;
      logic [6:0]  pend;
      logic [15:0] demand;
      logic        woken;
      logic        sync_dem;
      logic        dropped;
      logic        in_list;
   } ctl_event_type;

   typedef struct packed {
      logic [5:0]  sess_win;
      logic [21:0] glob_win;
      logic [21:0] in_use;
      logic [15:0] woken_cnt;
   } grant_type;

   typedef struct {
      ctl_event_type ev;
      bit            typed;
      grant_type     want;
   } script_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CORES_W-1:0]     csr_data = '0;

   // predictor state
   logic [STATE_W-1:0]     glob;
   logic [STATE_W-1:0]     used;
   logic [CORES_W-1:0]     cores;

   grant_type      grant_q[$];
   script_row_type script[$];
   grant_type      want;
   int             mismatch_cnt = 0;
   int             burst_left = 0;
   int             stall_mode = 0;
   int             stall_hold = 0;
   int             cores_plan[4];

   rpc_credit_window_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   initial begin
      #(12 * 400000);
      $display("[rpc_credit_window_controller] ERROR");
      $finish;
   end

   function automatic logic [STATE_W-1:0] pin_state(input longint v);
      logic [STATE_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > STATE_CEIL) begin
         r = STATE_CEIL[STATE_W-1:0];
      end else begin
         r = v[STATE_W-1:0];
      end
      return r;
   endfunction

   function automatic longint lmin(input longint a, input longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic longint lmax(input longint a, input longint b);
      return (a > b) ? a : b;
   endfunction

   // Applies one control event to the credit state and returns the resulting grant.
   function automatic grant_type advance_credits(input ctl_event_type e);
      longint w, open, wk, sw, old, pend, dem, sess, divisor, margin, tgt, f, gw, cu, mc;
      grant_type g;
      old  = longint'(e.old_win);
      pend = longint'(e.pend);
      dem  = longint'(e.demand);
      sess = longint'(e.sessions);
      gw   = longint'(glob);
      cu   = longint'(used);
      mc   = longint'(cores);
      sw   = old;
      wk   = 0;
      case (e.cmd)
         CMD_TICK: begin
            w = gw;
            if (longint'(e.delay) >= KNEE_US) begin
               f = lmax(480 - longint'(e.delay), 200);
               w = (w * f) / 400;
            end else begin
               w = w + lmax(sess / 500, 1);
            end
            w = lmax(w, mc);
            w = lmin(w, sess * SESS_CAP);
            open = w - cu;
            if (open > 0) begin
               wk = lmin(open, longint'(e.drained));
            end
            glob = pin_state(w);
            used = pin_state(cu + wk);
         end
         CMD_UPDATE: begin
            if (!e.in_list) begin
               open    = gw - cu;
               divisor = (sess == 0) ? 1 : sess;
               margin  = (open > 0) ? lmax(open / divisor, 1) : 1;
               if (cu < gw) begin
                  sw = lmin(pend + dem + margin, sw + open);
               end else if (cu > gw) begin
                  sw = sw - 1;
               end
               if (e.woken || sess <= mc) begin
                  sw = lmax(sw, margin);
               end
               if (old > 0 && sw == 0 && !e.dropped && !e.sync_dem) begin
                  sw = margin;
               end
               sw = lmax(sw, pend);
               sw = lmin(sw, SESS_CAP - 1);
               sw = lmin(sw, pend + dem + margin);
               used = pin_state(cu + (sw - old));
            end
         end
         CMD_TRIM: begin
            tgt = pend + dem;
            if (old > tgt) begin
               sw = tgt;
               used = pin_state(cu - (old - tgt));
            end
         end
         default: begin
            used = pin_state(cu - old);
            sw = 0;
         end
      endcase
      g.sess_win  = sw[5:0];
      g.glob_win  = glob[21:0];
      g.in_use    = used[21:0];
      g.woken_cnt = wk[15:0];
      return g;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_event(input ctl_event_type e);
      return {7'd0, e.in_list, e.dropped, e.sync_dem, e.woken, e.demand, e.pend, e.old_win,
              e.drained, e.sessions, e.delay};
   endfunction

   task automatic flag_mismatch(input string msg);
      if (mismatch_cnt < 40) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      mismatch_cnt++;
   endtask

   task automatic add_row(input cmd_type c, input int dly, input int sess, input int drn,
                          input int old, input int pend, input int dem, input bit [3:0] fl,
                          input bit typed = 1'b0, input int sw = 0, input int gw = 0,
                          input int cu = 0, input int wk = 0);
      script_row_type r;
      r.ev.cmd      = c;
      r.ev.delay    = dly[15:0];
      r.ev.sessions = sess[15:0];
      r.ev.drained  = drn[15:0];
      r.ev.old_win  = old[5:0];
      r.ev.pend     = pend[6:0];
      r.ev.demand   = dem[15:0];
      {r.ev.in_list, r.ev.dropped, r.ev.sync_dem, r.ev.woken} = fl;
      r.typed          = typed;
      r.want.sess_win  = sw[5:0];
      r.want.glob_win  = gw[21:0];
      r.want.in_use    = cu[21:0];
      r.want.woken_cnt = wk[15:0];
      script.push_back(r);
   endtask

   // One request transfer; the predictor runs at the accepting edge.
   task automatic push_event(input ctl_event_type e, input bit typed, input grant_type fixed);
      grant_type g;
      req_tdata  <= pack_event(e);
      req_tuser  <= e.cmd;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      g = advance_credits(e);
      grant_q.push_back(typed ? fixed : g);
   endtask

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 10);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_cores(input int v);
      csr_data  <= v[CORES_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      cores = v[CORES_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic ctl_event_type draw_event();
      ctl_event_type e;
      int k;
      k = $urandom_range(0, 99);
      if (k < 35) begin
         e.cmd = CMD_TICK;
      end else if (k < 75) begin
         e.cmd = CMD_UPDATE;
      end else if (k < 87) begin
         e.cmd = CMD_TRIM;
      end else begin
         e.cmd = CMD_RELEASE;
      end
      k = $urandom_range(0, 9);
      if (k == 0) begin
         e.sessions = '0;
      end else if (k < 4) begin
         e.sessions = 16'($urandom_range(1, 300));
      end else if (k < 8) begin
         e.sessions = 16'($urandom_range(300, 8000));
      end else begin
         e.sessions = 16'($urandom());
      end
      k = $urandom_range(0, 9);
      if (k < 6) begin
         e.delay = 16'($urandom_range(0, 79));
      end else if (k < 9) begin
         e.delay = 16'($urandom_range(80, 480));
      end else begin
         e.delay = 16'($urandom());
      end
      k = $urandom_range(0, 9);
      if (k < 3) begin
         e.drained = '0;
      end else if (k < 8) begin
         e.drained = 16'($urandom_range(0, 200));
      end else begin
         e.drained = 16'($urandom());
      end
      e.old_win  = 6'($urandom_range(0, 63));
      e.pend     = 7'($urandom_range(0, 64));
      e.demand   = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 40)) : 16'($urandom());
      e.woken    = 1'($urandom_range(0, 1));
      e.sync_dem = ($urandom_range(0, 3) == 0);
      e.dropped  = ($urandom_range(0, 3) == 0);
      e.in_list  = ($urandom_range(0, 5) == 0);
      return e;
   endfunction

   // receiver stall pattern, switching mode whenever its hold count runs out
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_hold = $urandom_range(20, 200);
      end else begin
         stall_hold--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= ($urandom_range(0, 4) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grant_q.size() == 0) begin
            flag_mismatch("result transfer with nothing expected");
         end else begin
            want = grant_q.pop_front();
            if (rsp_tdata[5:0] != want.sess_win)
               flag_mismatch($sformatf("session_window got %0d want %0d",
                                       rsp_tdata[5:0], want.sess_win));
            if (rsp_tdata[27:6] != want.glob_win)
               flag_mismatch($sformatf("global_window got %0d want %0d",
                                       rsp_tdata[27:6], want.glob_win));
            if (rsp_tdata[49:28] != want.in_use)
               flag_mismatch($sformatf("credits_in_use got %0d want %0d",
                                       rsp_tdata[49:28], want.in_use));
            if (rsp_tdata[65:50] != want.woken_cnt)
               flag_mismatch($sformatf("wake_count got %0d want %0d",
                                       rsp_tdata[65:50], want.woken_cnt));
         end
      end
   end

   initial begin
      glob  = STATE_W'(CORES_RST);
      used  = '0;
      cores = CORES_RST;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, flags are {in_list, dropped, sync, wake}
      add_row(CMD_RELEASE, 0, 0, 0, 0, 0, 0, 4'b0000, 1, 0, 8, 0, 0);
      add_row(CMD_TRIM, 0, 0, 0, 63, 0, 0, 4'b0000, 1, 0, 8, 0, 0);
      add_row(CMD_TICK, 0, 0, 65535, 0, 0, 0, 4'b0000, 1, 0, 0, 0, 0);
      add_row(CMD_TICK, 65535, 65535, 0, 63, 0, 0, 4'b0000, 1, 63, 8, 0, 0);
      add_row(CMD_TICK, 79, 65535, 65535, 0, 0, 0, 4'b0000, 1, 0, 139, 139, 139);
      add_row(CMD_UPDATE, 0, 5, 0, 63, 64, 65535, 4'b1000, 1, 63, 139, 139, 0);
      add_row(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 4'b0000);
      add_row(CMD_UPDATE, 0, 65535, 0, 10, 64, 65535, 4'b0001);
      add_row(CMD_RELEASE, 0, 0, 0, 63, 0, 0, 4'b0000);
      add_row(CMD_TICK, 280, 2, 5, 0, 0, 0, 4'b0000);
      add_row(CMD_UPDATE, 0, 1000, 0, 1, 0, 0, 4'b0000);
      add_row(CMD_UPDATE, 0, 1000, 0, 1, 0, 5, 4'b0100);
      add_row(CMD_UPDATE, 0, 1000, 0, 1, 0, 5, 4'b0010);
      add_row(CMD_TRIM, 0, 0, 0, 5, 3, 1, 4'b0000);
      add_row(CMD_TRIM, 0, 0, 0, 5, 64, 0, 4'b0000);
      add_row(CMD_TICK, 100, 20, 300, 7, 0, 0, 4'b0000);
      add_row(CMD_TICK, 0, 1, 1, 0, 0, 0, 4'b0000);
      add_row(CMD_UPDATE, 0, 65535, 0, 63, 0, 65535, 4'b0111);
      add_row(CMD_UPDATE, 0, 3, 0, 0, 64, 0, 4'b0001);
      add_row(CMD_RELEASE, 0, 0, 0, 63, 0, 0, 4'b0000);
      add_row(CMD_TICK, 65535, 65535, 65535, 0, 0, 0, 4'b0000);
      foreach (script[i]) begin
         push_event(script[i].ev, script[i].typed, script[i].want);
         pace();
      end

      cores_plan[0] = 1;
      cores_plan[1] = 256;
      cores_plan[2] = $urandom_range(2, 255);
      cores_plan[3] = 8;
      foreach (cores_plan[p]) begin
         settle();
         write_cores(cores_plan[p]);
         repeat (180) begin
            push_event(draw_event(), 1'b0, '0);
            if ($urandom_range(0, 99) == 0) begin
               settle();
            end else begin
               pace();
            end
         end
      end

      settle();
      if (grant_q.size() != 0) begin
         flag_mismatch("expected results left over");
      end
      if (mismatch_cnt == 0) begin
         $display("[rpc_credit_window_controller] OK");
      end else begin
         $display("[rpc_credit_window_controller] ERROR");
      end
      $finish;
   end

endmodule
